>>> rtl/core/tcp_pkg.sv
// ----------------------------------------------------------------------------
// tcp_pkg
// Shared types, constants and tables for the texture coordinate projector.
// ----------------------------------------------------------------------------
package tcp_pkg;

    localparam int COORD_FRAC_BITS = 16;
    localparam int CORDIC_STAGES   = 20;
    localparam int ATAN_LEN        = 30;
    localparam int DW              = 33;   // difference width
    localparam int NW              = 41;   // normalized operand width
    localparam int CW              = 46;   // cordic datapath width
    localparam int NORM_MSB        = 39;
    localparam int HALF            = 1 << (COORD_FRAC_BITS - 1);
    localparam int EPS             = ((9 << COORD_FRAC_BITS) + 5000) / 10000;

    localparam logic [21:0] GAIN_Q20 = 22'd1726753;

    localparam logic [31:0] ATAN_TURNS [ATAN_LEN] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
        32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
        32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
        32'd20,        32'd10,        32'd5,         32'd3,        32'd1
    };

    localparam logic [2:0] REG_MODE  = 3'd0;
    localparam logic [2:0] REG_AXIS  = 3'd1;
    localparam logic [2:0] REG_CX    = 3'd2;
    localparam logic [2:0] REG_CY    = 3'd3;
    localparam logic [2:0] REG_CZ    = 3'd4;
    localparam logic [2:0] REG_ISX   = 3'd5;
    localparam logic [2:0] REG_ISY   = 3'd6;
    localparam logic [2:0] REG_ISZ   = 3'd7;

    localparam logic [1:0] MODE_PLANAR = 2'd0;
    localparam logic [1:0] MODE_CYL    = 2'd1;
    localparam logic [1:0] MODE_SPH    = 2'd2;
    localparam logic [1:0] MODE_CUBIC  = 2'd3;

    localparam logic [1:0] AX_X = 2'd0;
    localparam logic [1:0] AX_Y = 2'd1;
    localparam logic [1:0] AX_Z = 2'd2;

    localparam logic [1:0] ACT_SET  = 2'd0;
    localparam logic [1:0] ACT_KEEP = 2'd1;
    localparam logic [1:0] ACT_COPY = 2'd2;

    typedef struct packed {
        logic [1:0]         mode;
        logic [1:0]         axis;
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic signed [31:0] center_z;
        logic signed [31:0] inv_size_x;
        logic signed [31:0] inv_size_y;
        logic signed [31:0] inv_size_z;
    } cfg_t;

    typedef struct packed {
        logic [1:0]           mode;
        logic signed [31:0]   tu;
        logic signed [31:0]   tv;
        logic signed [NW-1:0] bn;
        logic                 has_old;
        logic signed [31:0]   old_u;
        logic signed [31:0]   old_v;
        logic [31:0]          hd;
        logic                 rc_zero;
    } side_t;

endpackage

>>> rtl/core/tcp_cfg.sv
// ----------------------------------------------------------------------------
// tcp_cfg
// Register file behind the apb port.
// ----------------------------------------------------------------------------
module tcp_cfg (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [4:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    output tcp_pkg::cfg_t cfg
);
    import tcp_pkg::*;

    cfg_t cfg_reg;

    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode       <= MODE_PLANAR;
            cfg_reg.axis       <= AX_X;
            cfg_reg.center_x   <= '0;
            cfg_reg.center_y   <= '0;
            cfg_reg.center_z   <= '0;
            cfg_reg.inv_size_x <= 32'sd65536;
            cfg_reg.inv_size_y <= 32'sd65536;
            cfg_reg.inv_size_z <= 32'sd65536;
        end
        else if (psel && penable && pwrite && pready)
        begin
            unique case (paddr[4:2])
                REG_MODE: cfg_reg.mode       <= pwdata[1:0];
                REG_AXIS: cfg_reg.axis       <= pwdata[1:0];
                REG_CX:   cfg_reg.center_x   <= pwdata;
                REG_CY:   cfg_reg.center_y   <= pwdata;
                REG_CZ:   cfg_reg.center_z   <= pwdata;
                REG_ISX:  cfg_reg.inv_size_x <= pwdata;
                REG_ISY:  cfg_reg.inv_size_y <= pwdata;
                REG_ISZ:  cfg_reg.inv_size_z <= pwdata;
                default:  cfg_reg.mode       <= cfg_reg.mode;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            REG_MODE: prdata = {30'd0, cfg_reg.mode};
            REG_AXIS: prdata = {30'd0, cfg_reg.axis};
            REG_CX:   prdata = cfg_reg.center_x;
            REG_CY:   prdata = cfg_reg.center_y;
            REG_CZ:   prdata = cfg_reg.center_z;
            REG_ISX:  prdata = cfg_reg.inv_size_x;
            REG_ISY:  prdata = cfg_reg.inv_size_y;
            REG_ISZ:  prdata = cfg_reg.inv_size_z;
            default:  prdata = '0;
        endcase
    end

endmodule

>>> rtl/core/tcp_front.sv
// ----------------------------------------------------------------------------
// tcp_front
// Five-stage front end: centering, axis choice, operand selection, planar
// scaling and normalization of the cordic operands.
// ----------------------------------------------------------------------------
module tcp_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  tcp_pkg::cfg_t             cfg,
    input  logic                      in_valid,
    input  logic signed [31:0]        pos_x,
    input  logic signed [31:0]        pos_y,
    input  logic signed [31:0]        pos_z,
    input  logic signed [31:0]        normal_x,
    input  logic signed [31:0]        normal_y,
    input  logic signed [31:0]        normal_z,
    input  logic                      has_old_coord,
    input  logic signed [31:0]        old_u,
    input  logic signed [31:0]        old_v,
    output logic                      out_valid,
    output logic signed [tcp_pkg::CW-1:0] out_x,
    output logic signed [tcp_pkg::CW-1:0] out_y,
    output tcp_pkg::side_t            out_side
);
    import tcp_pkg::*;

    localparam int F = COORD_FRAC_BITS;

    logic [4:0] valid_reg;

    // stage 1
    logic signed [DW-1:0] dx1_reg, dy1_reg, dz1_reg;
    logic [1:0]           mode1_reg, ax1_reg;
    logic                 old1_reg;
    logic signed [31:0]   ou1_reg, ov1_reg;
    logic signed [DW-1:0] dx_next, dy_next, dz_next;
    logic [DW-1:0]        nxa, nya, nza;
    logic [1:0]           mode_next, ax_next;

    // stage 2
    logic signed [DW-1:0] uop2_reg, vop2_reg, pa2_reg, pc2_reg, pb2_reg;
    logic signed [31:0]   uinv2_reg, vinv2_reg;
    logic [1:0]           mode2_reg;
    logic                 old2_reg;
    logic signed [31:0]   ou2_reg, ov2_reg;
    logic signed [DW-1:0] uop_next, vop_next, pa_next, pc_next, pb_next;
    logic signed [31:0]   uinv_next, vinv_next;

    // stage 3
    logic signed [64:0]   pu3_reg, pv3_reg;
    logic [DW-1:0]        mx3_reg;
    logic signed [DW-1:0] pa3_reg, pc3_reg, pb3_reg;
    logic [1:0]           mode3_reg;
    logic                 old3_reg;
    logic signed [31:0]   ou3_reg, ov3_reg;
    logic [DW-1:0]        aa, ac, ab, mx_next;

    // stage 4
    logic signed [31:0]   tu4_reg, tv4_reg;
    logic [5:0]           sh4_reg;
    logic signed [DW-1:0] pa4_reg, pc4_reg, pb4_reg;
    logic [1:0]           mode4_reg;
    logic                 old4_reg;
    logic signed [31:0]   ou4_reg, ov4_reg;
    logic signed [48:0]   su, sv;
    logic signed [31:0]   tu_next, tv_next;
    logic [5:0]           msb;

    // stage 5
    logic signed [CW-1:0] x5_reg, y5_reg;
    side_t                side5_reg;
    logic signed [NW-1:0] paw, pcw, pbw;

    function automatic logic [DW-1:0] abs33(input logic signed [DW-1:0] a);
        abs33 = a[DW-1] ? DW'(-a) : DW'(a);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [48:0] a);
        if (a > 49'sd2147483647)
            sat32 = 32'sh7fffffff;
        else if (a < -49'sd2147483648)
            sat32 = 32'sh80000000;
        else
            sat32 = a[31:0];
    endfunction

    always_comb
    begin
        dx_next = DW'(pos_x) - DW'(cfg.center_x);
        dy_next = DW'(pos_y) - DW'(cfg.center_y);
        dz_next = DW'(pos_z) - DW'(cfg.center_z);
        nxa = abs33(DW'(normal_x));
        nya = abs33(DW'(normal_y));
        nza = abs33(DW'(normal_z));
        mode_next = cfg.mode;
        ax_next   = (cfg.axis == 2'd3) ? AX_Z : cfg.axis;
        if (cfg.mode == MODE_CUBIC)
        begin
            // ties go to z, then y
            mode_next = MODE_PLANAR;
            ax_next   = AX_X;
            if (nya >= nxa && nya >= nza)
                ax_next = AX_Y;
            if (nza >= nxa && nza >= nya)
                ax_next = AX_Z;
        end
    end

    always_comb
    begin
        unique case (ax1_reg)
            AX_X:
            begin
                pa_next = dz1_reg;  pc_next = -dy1_reg; pb_next = dx1_reg;
                uop_next = dz1_reg; uinv_next = cfg.inv_size_z;
                vop_next = -dy1_reg; vinv_next = cfg.inv_size_y;
            end
            AX_Y:
            begin
                pa_next = -dx1_reg; pc_next = dz1_reg;  pb_next = dy1_reg;
                uop_next = dx1_reg; uinv_next = cfg.inv_size_x;
                vop_next = -dz1_reg; vinv_next = cfg.inv_size_z;
            end
            default:
            begin
                pa_next = -dx1_reg; pc_next = -dy1_reg; pb_next = dz1_reg;
                uop_next = dx1_reg; uinv_next = cfg.inv_size_x;
                vop_next = -dy1_reg; vinv_next = cfg.inv_size_y;
            end
        endcase
        if (mode1_reg != MODE_PLANAR)
        begin
            // axial term scaled for the cylindrical v
            vop_next = -pb_next;
            unique case (ax1_reg)
                AX_X:    vinv_next = cfg.inv_size_x;
                AX_Y:    vinv_next = cfg.inv_size_y;
                default: vinv_next = cfg.inv_size_z;
            endcase
        end
    end

    always_comb
    begin
        aa = abs33(pa2_reg);
        ac = abs33(pc2_reg);
        ab = abs33(pb2_reg);
        mx_next = aa;
        if (ac > mx_next)
            mx_next = ac;
        if (ab > mx_next)
            mx_next = ab;
    end

    always_comb
    begin
        su = 49'(pu3_reg >>> F) + 49'(HALF);
        sv = 49'(pv3_reg >>> F) + 49'(HALF);
        tu_next = sat32(su);
        if (mode3_reg == MODE_PLANAR)
            tv_next = sat32(sv);
        else
            tv_next = 32'({sv[F-1:0]});
        msb = '0;
        for (int i = 0; i < DW; i++)
        begin
            if (mx3_reg[i])
                msb = 6'(i);
        end
    end

    always_comb
    begin
        paw = NW'(pa4_reg) <<< sh4_reg;
        pcw = NW'(pc4_reg) <<< sh4_reg;
        pbw = NW'(pb4_reg) <<< sh4_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[3:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx1_reg <= dx_next; dy1_reg <= dy_next; dz1_reg <= dz_next;
            mode1_reg <= mode_next; ax1_reg <= ax_next;
            old1_reg <= has_old_coord; ou1_reg <= old_u; ov1_reg <= old_v;

            uop2_reg <= uop_next; vop2_reg <= vop_next;
            uinv2_reg <= uinv_next; vinv2_reg <= vinv_next;
            pa2_reg <= pa_next; pc2_reg <= pc_next; pb2_reg <= pb_next;
            mode2_reg <= mode1_reg;
            old2_reg <= old1_reg; ou2_reg <= ou1_reg; ov2_reg <= ov1_reg;

            pu3_reg <= uop2_reg * uinv2_reg;
            pv3_reg <= vop2_reg * vinv2_reg;
            mx3_reg <= mx_next;
            pa3_reg <= pa2_reg; pc3_reg <= pc2_reg; pb3_reg <= pb2_reg;
            mode3_reg <= mode2_reg;
            old3_reg <= old2_reg; ou3_reg <= ou2_reg; ov3_reg <= ov2_reg;

            tu4_reg <= tu_next; tv4_reg <= tv_next;
            sh4_reg <= 6'(NORM_MSB) - msb;
            pa4_reg <= pa3_reg; pc4_reg <= pc3_reg; pb4_reg <= pb3_reg;
            mode4_reg <= mode3_reg;
            old4_reg <= old3_reg; ou4_reg <= ou3_reg; ov4_reg <= ov3_reg;

            x5_reg <= CW'(pcw);
            y5_reg <= CW'(-paw);
            side5_reg.mode    <= mode4_reg;
            side5_reg.tu      <= tu4_reg;
            side5_reg.tv      <= tv4_reg;
            side5_reg.bn      <= pbw;
            side5_reg.has_old <= old4_reg;
            side5_reg.old_u   <= ou4_reg;
            side5_reg.old_v   <= ov4_reg;
            side5_reg.hd      <= '0;
            side5_reg.rc_zero <= 1'b0;
        end
    end

    assign out_valid = valid_reg[4];
    assign out_x     = x5_reg;
    assign out_y     = y5_reg;
    assign out_side  = side5_reg;

endmodule

>>> rtl/core/tcp_cordic.sv
// ----------------------------------------------------------------------------
// tcp_cordic
// Pipelined vectoring cordic: angle in turns and gain-scaled magnitude,
// one pre-rotation stage and one register stage per iteration.
// ----------------------------------------------------------------------------
module tcp_cordic (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic signed [tcp_pkg::CW-1:0] in_x,
    input  logic signed [tcp_pkg::CW-1:0] in_y,
    input  tcp_pkg::side_t                in_side,
    output logic                          out_valid,
    output logic [31:0]                   out_acc,
    output logic signed [tcp_pkg::CW-1:0] out_mag,
    output tcp_pkg::side_t                out_side
);
    import tcp_pkg::*;

    localparam int N = CORDIC_STAGES;

    logic                 v_reg    [0:N];
    logic                 zero_reg [0:N];
    logic signed [CW-1:0] x_reg    [0:N];
    logic signed [CW-1:0] y_reg    [0:N];
    logic [31:0]          acc_reg  [0:N];
    side_t                side_reg [0:N];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else if (en)
            v_reg[0] <= in_valid;
    end

    // fold the left half plane over
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zero_reg[0] <= (in_x == '0) && (in_y == '0);
            side_reg[0] <= in_side;
            if (in_x < 0)
            begin
                x_reg[0]   <= -in_x;
                y_reg[0]   <= -in_y;
                acc_reg[0] <= 32'h80000000;
            end
            else
            begin
                x_reg[0]   <= in_x;
                y_reg[0]   <= in_y;
                acc_reg[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < N; i++)
    begin : g_iter
        logic signed [CW-1:0] x_next, y_next;
        logic [31:0]          acc_next;

        always_comb
        begin
            if (y_reg[i] > 0)
            begin
                x_next   = x_reg[i] + (y_reg[i] >>> i);
                y_next   = y_reg[i] - (x_reg[i] >>> i);
                acc_next = acc_reg[i] + ATAN_TURNS[i];
            end
            else
            begin
                x_next   = x_reg[i] - (y_reg[i] >>> i);
                y_next   = y_reg[i] + (x_reg[i] >>> i);
                acc_next = acc_reg[i] - ATAN_TURNS[i];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[i+1] <= 1'b0;
            else if (en)
                v_reg[i+1] <= v_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[i+1]    <= x_next;
                y_reg[i+1]    <= y_next;
                acc_reg[i+1]  <= acc_next;
                zero_reg[i+1] <= zero_reg[i];
                side_reg[i+1] <= side_reg[i];
            end
        end
    end

    assign out_valid = v_reg[N];
    assign out_acc   = zero_reg[N] ? '0 : acc_reg[N];
    assign out_mag   = zero_reg[N] ? '0 : x_reg[N];
    assign out_side  = side_reg[N];

endmodule

>>> rtl/core/texture_coordinate_projector.sv
// ----------------------------------------------------------------------------
// texture_coordinate_projector
// Planar, cylindrical, spherical and cubic texture coordinate projection.
// ----------------------------------------------------------------------------
// One vertex word is taken per clock while the pipeline advances; it passes
// through two 21-stage cordic pipelines (heading, then pitch) behind a
// five-stage front end, two gain-multiply stages, one select stage and the
// output register. The whole pipeline advances whenever the output register
// is empty or being taken, so a stall on the output freezes every stage and
// nothing is lost or repeated. Registers must be written over apb only while
// no vertex is in flight; the block itself does not enforce this.
module texture_coordinate_projector (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    // pos_x, pos_y, pos_z, normal_x, normal_y, normal_z, old_u, old_v
    input  logic [255:0]  s_tdata,
    // has_old_coord
    input  logic          s_tuser,
    output logic          m_tvalid,
    input  logic          m_tready,
    // tex_u, tex_v
    output logic [63:0]   m_tdata,
    // vertex_action
    output logic [1:0]    m_tuser,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [4:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);
    import tcp_pkg::*;

    localparam int F = COORD_FRAC_BITS;

    cfg_t                 cfg;
    logic                 en;

    logic                 fe_valid;
    logic signed [CW-1:0] fe_x, fe_y;
    side_t                fe_side;

    logic                 c1_valid;
    logic [31:0]          c1_acc;
    logic signed [CW-1:0] c1_mag;
    side_t                c1_side;

    logic                 p1_valid_reg;
    logic signed [42:0]   bhk_reg;
    logic [41:0]          blk_reg;
    logic signed [CW-1:0] rc_reg;
    side_t                p1_side_reg;
    side_t                p1_side_next;

    logic                 p2_valid_reg;
    logic signed [CW-1:0] p2_x_reg, p2_y_reg;
    side_t                p2_side_reg;

    logic                 c2_valid;
    logic [31:0]          c2_acc;
    logic signed [CW-1:0] c2_mag;
    side_t                c2_side;

    logic                 f1_valid_reg;
    logic signed [31:0]   f1_tu_reg, f1_tv_reg;
    logic                 f1_old_reg;
    logic signed [31:0]   f1_ou_reg, f1_ov_reg;
    logic [31:0]          pt, tvs;
    logic signed [31:0]   tu_next, tv_next;

    logic                 out_valid_reg;
    logic [63:0]          out_data_reg;
    logic [1:0]           out_user_reg;
    logic signed [32:0]   du, dv;
    logic [32:0]          dua, dva;
    logic [1:0]           act_next;

    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    tcp_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tcp_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en),
        .cfg           (cfg),
        .in_valid      (s_tvalid),
        .pos_x         (s_tdata[31:0]),
        .pos_y         (s_tdata[63:32]),
        .pos_z         (s_tdata[95:64]),
        .normal_x      (s_tdata[127:96]),
        .normal_y      (s_tdata[159:128]),
        .normal_z      (s_tdata[191:160]),
        .has_old_coord (s_tuser),
        .old_u         (s_tdata[223:192]),
        .old_v         (s_tdata[255:224]),
        .out_valid     (fe_valid),
        .out_x         (fe_x),
        .out_y         (fe_y),
        .out_side      (fe_side)
    );

    tcp_cordic u_heading (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (fe_valid),
        .in_x      (fe_x),
        .in_y      (fe_y),
        .in_side   (fe_side),
        .out_valid (c1_valid),
        .out_acc   (c1_acc),
        .out_mag   (c1_mag),
        .out_side  (c1_side)
    );

    // gain compensation of b, split in high and low partial products
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            f1_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            p1_valid_reg  <= c1_valid;
            p2_valid_reg  <= p1_valid_reg;
            f1_valid_reg  <= c2_valid;
            out_valid_reg <= f1_valid_reg;
        end
    end

    always_comb
    begin
        p1_side_next         = c1_side;
        p1_side_next.hd      = c1_acc;
        p1_side_next.rc_zero = (c1_mag == '0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bhk_reg <= $signed(c1_side.bn[NW-1:20]) * $signed(GAIN_Q20);
            blk_reg <= c1_side.bn[19:0] * GAIN_Q20;
            rc_reg  <= c1_mag;
            p1_side_reg <= p1_side_next;

            p2_x_reg    <= rc_reg;
            p2_y_reg    <= CW'(bhk_reg) + CW'(blk_reg[41:20]);
            p2_side_reg <= p1_side_reg;
        end
    end

    tcp_cordic u_pitch (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (p2_valid_reg),
        .in_x      (p2_x_reg),
        .in_y      (p2_y_reg),
        .in_side   (p2_side_reg),
        .out_valid (c2_valid),
        .out_acc   (c2_acc),
        .out_mag   (c2_mag),
        .out_side  (c2_side)
    );

    always_comb
    begin
        // on the axis the pitch is a quarter turn by the sign of b
        if (c2_side.rc_zero)
        begin
            if (c2_side.bn > 0)
                pt = 32'h40000000;
            else if (c2_side.bn < 0)
                pt = 32'hc0000000;
            else
                pt = '0;
        end
        else
            pt = c2_acc;
        tvs = 32'h80000000 - {pt[30:0], 1'b0};
        case (c2_side.mode)
            MODE_CYL:
            begin
                tu_next = 32'((32'd0 - c2_side.hd) >> (32 - F));
                tv_next = c2_side.tv;
            end
            MODE_SPH:
            begin
                tu_next = 32'(c2_side.hd >> (32 - F));
                tv_next = 32'(tvs >> (32 - F));
            end
            default:
            begin
                tu_next = c2_side.tu;
                tv_next = c2_side.tv;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f1_tu_reg  <= tu_next;
            f1_tv_reg  <= tv_next;
            f1_old_reg <= c2_side.has_old;
            f1_ou_reg  <= c2_side.old_u;
            f1_ov_reg  <= c2_side.old_v;
        end
    end

    always_comb
    begin
        du  = 33'(f1_ou_reg) - 33'(f1_tu_reg);
        dv  = 33'(f1_ov_reg) - 33'(f1_tv_reg);
        dua = du[32] ? 33'(-du) : 33'(du);
        dva = dv[32] ? 33'(-dv) : 33'(dv);
        if (!f1_old_reg)
            act_next = ACT_SET;
        else if (dua > 33'(EPS) || dva > 33'(EPS))
            act_next = ACT_COPY;
        else
            act_next = ACT_KEEP;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= {f1_tv_reg, f1_tu_reg};
            out_user_reg <= act_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    // a finished word in the select stage reaches the output in the following cycle when the pipeline advances
    a_f1_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        en && f1_valid_reg |=> out_valid_reg)
        else $error("select stage word did not reach the output");

    a_action_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_user_reg == ACT_SET || out_user_reg == ACT_KEEP ||
                           out_user_reg == ACT_COPY))
        else $error("bad vertex action code");

    a_no_old_sets: assert property (@(posedge clk) disable iff (!rst_n)
        en && f1_valid_reg && !f1_old_reg |=> out_user_reg == ACT_SET)
        else $error("vertex without old coordinate not set");

    a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(f1_tu_reg) && $stable(p2_y_reg))
        else $error("pipeline moved during a stall");

endmodule
